// ----- rtl/assert_macros.svh -----
// assertion macros used by the sparse vector store top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock edge, off while reset is asserted
`define SSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked on every rising clock edge, reset included
`define SSV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/ssv_pkg.sv -----
// types and constants of the sorted sparse vector store
package ssv_pkg;

  // payload widths fixed by the interface
  localparam int VALUE_W     = 32;
  localparam int MAG_W       = 31;
  localparam int POS_W       = 8;
  localparam int COUNT_OUT_W = 9;
  localparam int FUNC_W      = 2;

  // entries per group of the result collection tree
  localparam int GROUP_SEL_W = 4;
  localparam int GROUP_SIZE  = 1 << GROUP_SEL_W;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // configuration register select (address bit 2)
  localparam logic REG_FILTER_EN = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  // operation sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED,
    ST_APPLY
  } state_e;

  // command broadcast to every cell in the apply cycle
  typedef struct packed {
    logic ins;
    logic upd;
  } cell_cmd_t;

endpackage

// ----- rtl/sorted_sparse_vector_store.sv -----
// sorted sparse vector store: top level with sequencer, config port and cell chain
//
// Holds up to CAPACITY (index, value) pairs sorted by ascending index in a
// row of cells; an insert places the new entry and shifts every entry above
// it up by one cell, all in the apply cycle.
// Operation channel: a transaction is taken when start is high and busy is
// low. func selects insert, read of a sorted position, or clear; any other
// code only reports the entry count.
// Result channel: result_valid_o is high for one cycle with all result
// fields; the receiver cannot stall and must take it in that cycle.
// Timing: the result strobe rises after the accepting edge has passed through
// the states of compare in every cell, registered group stage of the
// match/read collection, and apply; busy is high through those states, so a
// new operation is not taken before its predecessor is through; the next one
// may be taken at the edge that ends its predecessor's result.
// Configuration: APB write/read of filter_enable (0x0) and threshold_magnitude
// (0x4); the user must do so only while no operation is in flight (not enforced).
// Reset: the entry count, the sequencer and the registers clear at once;
// entry storage is not cleared and no clearing pass is needed.
module sorted_sparse_vector_store #(
  parameter int CAPACITY    = 256,
  parameter int INDEX_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // operation channel
  input  logic                             start,
  output logic                             busy,
  input  logic [ssv_pkg::FUNC_W-1:0]       func_i,
  input  logic [INDEX_WIDTH-1:0]           index_i,
  input  logic [ssv_pkg::VALUE_W-1:0]      value_bits_i,
  input  logic [ssv_pkg::POS_W-1:0]        position_i,
  // result channel
  output logic                             result_valid_o,
  output logic [ssv_pkg::COUNT_OUT_W-1:0]  entry_count_o,
  output logic                             was_update_o,
  output logic                             was_dropped_full_o,
  output logic                             was_filtered_o,
  output logic                             read_hit_o,
  output logic [INDEX_WIDTH-1:0]           read_index_o,
  output logic [ssv_pkg::VALUE_W-1:0]      read_value_o,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  `include "assert_macros.svh"

  localparam int CntW    = $clog2(CAPACITY + 1);
  localparam int CntOutW = ssv_pkg::COUNT_OUT_W;
  localparam int MagW    = ssv_pkg::MAG_W;
  localparam int ValW    = ssv_pkg::VALUE_W;

  ssv_pkg::state_e              state_q, state_d;
  ssv_pkg::cell_cmd_t           cell_cmd;

  logic                         filter_en_q;
  logic [MagW-1:0]              thresh_q;
  logic                         cfg_wr;

  logic [CntW-1:0]              count_q, count_d;
  logic [ssv_pkg::FUNC_W-1:0]   op_func_q;
  logic [INDEX_WIDTH-1:0]       op_key_q;
  logic [ValW-1:0]              op_val_q;
  logic [ssv_pkg::POS_W-1:0]    op_pos_q;
  logic                         op_filt_q;
  logic                         accept;

  logic                         any_eq;
  logic [INDEX_WIDTH-1:0]       rd_idx;
  logic [ValW-1:0]              rd_val;
  logic                         full;
  logic                         is_insert;
  logic                         do_ins, do_upd, do_drop, do_filt, do_hit;

  logic                         res_valid_q;
  logic [CntOutW-1:0]           res_count_q;
  logic                         res_upd_q, res_drop_q, res_filt_q, res_hit_q;
  logic [INDEX_WIDTH-1:0]       res_idx_q;
  logic [ValW-1:0]              res_val_q;

  logic [INDEX_WIDTH-1:0]       cell_idx [CAPACITY];
  logic [ValW-1:0]              cell_val [CAPACITY];
  logic                         cell_lt  [CAPACITY];
  logic                         cell_eq  [CAPACITY];

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_en_q <= 1'b0;
      thresh_q    <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        ssv_pkg::REG_FILTER_EN: filter_en_q <= pwdata[0];
        ssv_pkg::REG_THRESHOLD: thresh_q    <= pwdata[MagW-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[2])
      ssv_pkg::REG_FILTER_EN: prdata = {31'b0, filter_en_q};
      ssv_pkg::REG_THRESHOLD: prdata = {1'b0, thresh_q};
      default:                prdata = '0;
    endcase
  end

  // operation capture, filter decided on the way in
  assign accept = start && !busy;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_func_q <= func_i;
      op_key_q  <= index_i;
      op_val_q  <= value_bits_i;
      op_pos_q  <= position_i;
      op_filt_q <= (func_i == ssv_pkg::FUNC_INSERT) && filter_en_q &&
                   (value_bits_i[MagW-1:0] <= thresh_q);
    end
  end

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // decision made in the apply cycle
  assign full      = (count_q == CntW'(CAPACITY));
  assign is_insert = (op_func_q == ssv_pkg::FUNC_INSERT);
  assign do_filt   = is_insert && op_filt_q;
  assign do_upd    = is_insert && !op_filt_q && any_eq;
  assign do_drop   = is_insert && !op_filt_q && !any_eq && full;
  assign do_ins    = is_insert && !op_filt_q && !any_eq && !full;
  assign do_hit    = (op_func_q == ssv_pkg::FUNC_READ) &&
                     (32'(op_pos_q) < 32'(count_q));

  always_comb begin
    case (op_func_q)
      ssv_pkg::FUNC_INSERT: count_d = do_ins ? count_q + CntW'(1) : count_q;
      ssv_pkg::FUNC_CLEAR:  count_d = '0;
      default:              count_d = count_q;
    endcase
  end

  // next state, busy and cell command
  always_comb begin
    state_d      = state_q;
    busy         = 1'b1;
    cell_cmd.ins = 1'b0;
    cell_cmd.upd = 1'b0;
    unique case (state_q)
      ssv_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_d = ssv_pkg::ST_CMP;
        end
      end
      ssv_pkg::ST_CMP: begin
        state_d = ssv_pkg::ST_RED;
      end
      ssv_pkg::ST_RED: begin
        state_d = ssv_pkg::ST_APPLY;
      end
      ssv_pkg::ST_APPLY: begin
        cell_cmd.ins = do_ins;
        cell_cmd.upd = do_upd;
        state_d      = ssv_pkg::ST_IDLE;
      end
      default: state_d = ssv_pkg::ST_IDLE;
    endcase
  end

  // entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (state_q == ssv_pkg::ST_APPLY) begin
      count_q <= count_d;
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (state_q == ssv_pkg::ST_APPLY);
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ssv_pkg::ST_APPLY) begin
      res_count_q <= CntOutW'(count_d);
      res_upd_q   <= do_upd;
      res_drop_q  <= do_drop;
      res_filt_q  <= do_filt;
      res_hit_q   <= do_hit;
      res_idx_q   <= do_hit ? rd_idx : '0;
      res_val_q   <= do_hit ? rd_val : '0;
    end
  end

  assign result_valid_o     = res_valid_q;
  assign entry_count_o      = res_count_q;
  assign was_update_o       = res_upd_q;
  assign was_dropped_full_o = res_drop_q;
  assign was_filtered_o     = res_filt_q;
  assign read_hit_o         = res_hit_q;
  assign read_index_o       = res_idx_q;
  assign read_value_o       = res_val_q;

  // chain of cells, each fed by its lower neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      ssv_cell #(
        .CAPACITY    (CAPACITY),
        .INDEX_WIDTH (INDEX_WIDTH),
        .CELL_POS    (i)
      ) u_cell (
        .clk_i      (clk_i),
        .cmd_i      (cell_cmd),
        .count_i    (count_q),
        .key_i      (op_key_q),
        .val_i      (op_val_q),
        .prev_idx_i (op_key_q),
        .prev_val_i (op_val_q),
        .prev_lt_i  (1'b1),
        .idx_o      (cell_idx[i]),
        .val_o      (cell_val[i]),
        .lt_o       (cell_lt[i]),
        .eq_o       (cell_eq[i])
      );
    end else begin : g_next
      ssv_cell #(
        .CAPACITY    (CAPACITY),
        .INDEX_WIDTH (INDEX_WIDTH),
        .CELL_POS    (i)
      ) u_cell (
        .clk_i      (clk_i),
        .cmd_i      (cell_cmd),
        .count_i    (count_q),
        .key_i      (op_key_q),
        .val_i      (op_val_q),
        .prev_idx_i (cell_idx[i-1]),
        .prev_val_i (cell_val[i-1]),
        .prev_lt_i  (cell_lt[i-1]),
        .idx_o      (cell_idx[i]),
        .val_o      (cell_val[i]),
        .lt_o       (cell_lt[i]),
        .eq_o       (cell_eq[i])
      );
    end
  end

  // match flag and read entry collection
  ssv_collect #(
    .CAPACITY    (CAPACITY),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_collect (
    .clk_i    (clk_i),
    .eq_i     (cell_eq),
    .idx_i    (cell_idx),
    .val_i    (cell_val),
    .sel_i    (op_pos_q),
    .any_eq_o (any_eq),
    .rd_idx_o (rd_idx),
    .rd_val_o (rd_val)
  );

  // assertions
  `SSV_ASSERT(a_strobe_after_apply, result_valid_o |-> $past(state_q == ssv_pkg::ST_APPLY), "result strobe without apply cycle")
  `SSV_ASSERT(a_accept_starts, accept |=> (state_q == ssv_pkg::ST_CMP), "accepted transaction did not start compare")
  `SSV_ASSERT(a_flags_exclusive, result_valid_o |-> $onehot0({was_update_o, was_dropped_full_o, was_filtered_o, read_hit_o}), "more than one result flag set")
  `SSV_ASSERT(a_count_bound, count_q <= CntW'(CAPACITY), "entry count above capacity")

endmodule

// ----- rtl/ssv_cell.sv -----
// one storage cell of the sorted chain: entry, compare flags and shift logic
module ssv_cell #(
  parameter int CAPACITY    = 256,
  parameter int INDEX_WIDTH = 16,
  parameter int CELL_POS    = 0
) (
  input  logic                                   clk_i,
  input  ssv_pkg::cell_cmd_t                     cmd_i,
  input  logic [$clog2(CAPACITY+1)-1:0]          count_i,
  input  logic [INDEX_WIDTH-1:0]                 key_i,
  input  logic [ssv_pkg::VALUE_W-1:0]            val_i,
  input  logic [INDEX_WIDTH-1:0]                 prev_idx_i,
  input  logic [ssv_pkg::VALUE_W-1:0]            prev_val_i,
  input  logic                                   prev_lt_i,
  output logic [INDEX_WIDTH-1:0]                 idx_o,
  output logic [ssv_pkg::VALUE_W-1:0]            val_o,
  output logic                                   lt_o,
  output logic                                   eq_o
);

  logic [INDEX_WIDTH-1:0]      idx_q, idx_d;
  logic [ssv_pkg::VALUE_W-1:0] val_q, val_d;
  logic                        lt_q, eq_q;
  logic                        valid;

  // entry is live when its position is below the count
  assign valid = (int'(count_i) > CELL_POS);

  // insert: first cell not below the key takes the new entry, cells above shift up
  always_comb begin
    idx_d = idx_q;
    val_d = val_q;
    if (cmd_i.ins) begin
      if (!lt_q) begin
        if (prev_lt_i) begin
          idx_d = key_i;
          val_d = val_i;
        end else begin
          idx_d = prev_idx_i;
          val_d = prev_val_i;
        end
      end
    end else if (cmd_i.upd && eq_q) begin
      val_d = val_i;
    end
  end

  // entry and compare flags
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    val_q <= val_d;
    lt_q  <= valid && (idx_q < key_i);
    eq_q  <= valid && (idx_q == key_i);
  end

  assign idx_o = idx_q;
  assign val_o = val_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

// ----- rtl/ssv_collect.sv -----
// registered group stage that gathers the match flag and the read entry
module ssv_collect #(
  parameter int CAPACITY    = 256,
  parameter int INDEX_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        eq_i  [CAPACITY],
  input  logic [INDEX_WIDTH-1:0]      idx_i [CAPACITY],
  input  logic [ssv_pkg::VALUE_W-1:0] val_i [CAPACITY],
  input  logic [ssv_pkg::POS_W-1:0]   sel_i,
  output logic                        any_eq_o,
  output logic [INDEX_WIDTH-1:0]      rd_idx_o,
  output logic [ssv_pkg::VALUE_W-1:0] rd_val_o
);

  localparam int GroupSize = ssv_pkg::GROUP_SIZE;
  localparam int SelLoW    = ssv_pkg::GROUP_SEL_W;
  localparam int NumGroups = (CAPACITY + GroupSize - 1) / GroupSize;
  localparam int GrpW      = (NumGroups > 1) ? $clog2(NumGroups) : 1;

  logic [SelLoW-1:0]           sel_lo;
  logic [GrpW-1:0]             sel_hi;
  logic [NumGroups-1:0]        grp_eq_d, grp_eq_q;
  logic [INDEX_WIDTH-1:0]      grp_idx_d [NumGroups];
  logic [INDEX_WIDTH-1:0]      grp_idx_q [NumGroups];
  logic [ssv_pkg::VALUE_W-1:0] grp_val_d [NumGroups];
  logic [ssv_pkg::VALUE_W-1:0] grp_val_q [NumGroups];

  assign sel_lo = sel_i[SelLoW-1:0];
  assign sel_hi = GrpW'(32'(sel_i) >> SelLoW);

  // per group: or of the match flags, entry picked by the low position bits
  always_comb begin
    int k;
    for (int g = 0; g < NumGroups; g++) begin
      grp_eq_d[g]  = 1'b0;
      grp_idx_d[g] = '0;
      grp_val_d[g] = '0;
      for (int j = 0; j < GroupSize; j++) begin
        k = g * GroupSize + j;
        if (k < CAPACITY) begin
          grp_eq_d[g] = grp_eq_d[g] | eq_i[k];
          if (sel_lo == SelLoW'(j)) begin
            grp_idx_d[g] = idx_i[k];
            grp_val_d[g] = val_i[k];
          end
        end
      end
    end
  end

  // group registers
  always_ff @(posedge clk_i) begin
    grp_eq_q  <= grp_eq_d;
    grp_idx_q <= grp_idx_d;
    grp_val_q <= grp_val_d;
  end

  // final level over the groups
  assign any_eq_o = |grp_eq_q;
  assign rd_idx_o = grp_idx_q[sel_hi];
  assign rd_val_o = grp_val_q[sel_hi];

endmodule
